### rtl/limit_order_matcher_macros.svh
// Assertion macros used by the order matcher sequencer (lom_ctrl).
`ifndef LIMIT_ORDER_MATCHER_MACROS_SVH
`define LIMIT_ORDER_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LOM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LOM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lom_pkg.sv
// Shared types and codes of the limit order matcher.
package lom_pkg;

  localparam int ID_W = 32;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_RESTED    = 3'd1,
    KIND_FILLED    = 3'd2,
    KIND_REJECTED  = 3'd3,
    KIND_CANCELLED = 3'd4,
    KIND_NOTFOUND  = 3'd5,
    KIND_FULL      = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_DEC,
    CMD_CLEAR,
    CMD_LOAD
  } cmd_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DECIDE
  } state_t;

  // valid flags of the three candidates passed down the cell chain
  typedef struct packed {
    logic best;
    logic hit;
    logic free;
  } link_vld_t;

endpackage

### rtl/lom_in_if.sv
// Request channel interface.
interface lom_in_if #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24
);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic                    is_buy;
  logic [PRICE_BITS-1:0]   limit_price;
  logic [QTY_BITS-1:0]     quantity;
  logic [lom_pkg::ID_W-1:0] cancel_id;

  modport source (output valid, mode, is_buy, limit_price, quantity, cancel_id, input ready);
  modport sink   (input valid, mode, is_buy, limit_price, quantity, cancel_id, output ready);
endinterface

### rtl/lom_out_if.sv
// Result channel interface.
interface lom_out_if #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic [lom_pkg::ID_W-1:0] req_id;
  logic [lom_pkg::ID_W-1:0] maker_id;
  logic [PRICE_BITS-1:0]    trade_price;
  logic [QTY_BITS-1:0]      fill_qty;
  logic [QTY_BITS-1:0]      left_qty;
  logic                     last;

  modport source (output valid, kind, req_id, maker_id, trade_price, fill_qty, left_qty,
                  last, input ready);
  modport sink   (input valid, kind, req_id, maker_id, trade_price, fill_qty, left_qty,
                  last, output ready);
endinterface

### rtl/limit_order_matcher.sv
// Top level: price-time priority order book built as a chain of slot cells.
// A request waits in S_WAIT for the chain to settle, then emits a word once the output is free.
// Each trade updates a slot, then starts a fresh pass down the chain before the next word.
// One request at a time: in_ch.ready is high only in S_IDLE.
// The candidate chain has one registered cell per slot.
// Reset (sync, rst_n low): all slots empty, next order id = 1, no clearing pass.
module limit_order_matcher #(
  parameter int MAX_ORDERS = 32,
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24
) (
  input logic        clk,
  input logic        rst_n,
  lom_in_if.sink     in_ch,
  lom_out_if.source  out_ch
);

  localparam int IW = $clog2(MAX_ORDERS);

  // query held stable while the chain settles
  logic                     q_buy;
  logic [PRICE_BITS-1:0]    q_limit;
  logic [lom_pkg::ID_W-1:0] q_cid;

  // slot write broadcast to every cell
  lom_pkg::cmd_op_t         cmd_op;
  logic [IW-1:0]            cmd_idx;
  logic [lom_pkg::ID_W-1:0] cmd_id;
  logic [PRICE_BITS-1:0]    cmd_price;
  logic [QTY_BITS-1:0]      cmd_qty;
  logic                     cmd_side;

  // chain links: link k feeds cell k, link MAX_ORDERS is the chain end
  lom_pkg::link_vld_t       lv    [MAX_ORDERS+1];
  logic [PRICE_BITS-1:0]    lprice[MAX_ORDERS+1];
  logic [lom_pkg::ID_W-1:0] lid   [MAX_ORDERS+1];
  logic [QTY_BITS-1:0]      lqty  [MAX_ORDERS+1];
  logic [IW-1:0]            lbidx [MAX_ORDERS+1];
  logic [IW-1:0]            lhidx [MAX_ORDERS+1];
  logic [IW-1:0]            lfidx [MAX_ORDERS+1];

  // head of chain: no candidates yet
  assign lv[0]     = '0;
  assign lprice[0] = '0;
  assign lid[0]    = '0;
  assign lqty[0]   = '0;
  assign lbidx[0]  = '0;
  assign lhidx[0]  = '0;
  assign lfidx[0]  = '0;

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lom_cell #(
      .PRICE_BITS(PRICE_BITS),
      .QTY_BITS  (QTY_BITS),
      .IW        (IW),
      .IDX       (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .q_buy    (q_buy),
      .q_limit  (q_limit),
      .q_cid    (q_cid),
      .cmd_op   (cmd_op),
      .cmd_idx  (cmd_idx),
      .cmd_id   (cmd_id),
      .cmd_price(cmd_price),
      .cmd_qty  (cmd_qty),
      .cmd_side (cmd_side),
      .vld_i    (lv[g]),
      .b_price_i(lprice[g]),
      .b_id_i   (lid[g]),
      .b_qty_i  (lqty[g]),
      .b_idx_i  (lbidx[g]),
      .h_idx_i  (lhidx[g]),
      .f_idx_i  (lfidx[g]),
      .vld_o    (lv[g+1]),
      .b_price_o(lprice[g+1]),
      .b_id_o   (lid[g+1]),
      .b_qty_o  (lqty[g+1]),
      .b_idx_o  (lbidx[g+1]),
      .h_idx_o  (lhidx[g+1]),
      .f_idx_o  (lfidx[g+1])
    );
  end

  // sequencer reads the chain end: best crossing order, cancel hit, lowest free slot
  lom_ctrl #(
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS),
    .MAX_ORDERS(MAX_ORDERS),
    .IW        (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .q_buy      (q_buy),
    .q_limit    (q_limit),
    .q_cid      (q_cid),
    .cmd_op     (cmd_op),
    .cmd_idx    (cmd_idx),
    .cmd_id     (cmd_id),
    .cmd_price  (cmd_price),
    .cmd_qty    (cmd_qty),
    .cmd_side   (cmd_side),
    .end_vld    (lv[MAX_ORDERS]),
    .end_b_price(lprice[MAX_ORDERS]),
    .end_b_id   (lid[MAX_ORDERS]),
    .end_b_qty  (lqty[MAX_ORDERS]),
    .end_b_idx  (lbidx[MAX_ORDERS]),
    .end_h_idx  (lhidx[MAX_ORDERS]),
    .end_f_idx  (lfidx[MAX_ORDERS])
  );

endmodule

### rtl/lom_cell.sv
// One book slot plus its registered stage of the candidate chain.
module lom_cell #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24,
  parameter int IW         = 5,
  parameter int IDX        = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_buy,
  input  logic [PRICE_BITS-1:0]      q_limit,
  input  logic [lom_pkg::ID_W-1:0]   q_cid,
  input  lom_pkg::cmd_op_t           cmd_op,
  input  logic [IW-1:0]              cmd_idx,
  input  logic [lom_pkg::ID_W-1:0]   cmd_id,
  input  logic [PRICE_BITS-1:0]      cmd_price,
  input  logic [QTY_BITS-1:0]        cmd_qty,
  input  logic                       cmd_side,
  input  lom_pkg::link_vld_t         vld_i,
  input  logic [PRICE_BITS-1:0]      b_price_i,
  input  logic [lom_pkg::ID_W-1:0]   b_id_i,
  input  logic [QTY_BITS-1:0]        b_qty_i,
  input  logic [IW-1:0]              b_idx_i,
  input  logic [IW-1:0]              h_idx_i,
  input  logic [IW-1:0]              f_idx_i,
  output lom_pkg::link_vld_t         vld_o,
  output logic [PRICE_BITS-1:0]      b_price_o,
  output logic [lom_pkg::ID_W-1:0]   b_id_o,
  output logic [QTY_BITS-1:0]        b_qty_o,
  output logic [IW-1:0]              b_idx_o,
  output logic [IW-1:0]              h_idx_o,
  output logic [IW-1:0]              f_idx_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                     valid_r;
  logic [lom_pkg::ID_W-1:0] id_r;
  logic [PRICE_BITS-1:0]    price_r;
  logic [QTY_BITS-1:0]      qty_r;
  logic                     side_r;
  lom_pkg::link_vld_t       vld_r;
  logic [PRICE_BITS-1:0]    b_price_r;
  logic [lom_pkg::ID_W-1:0] b_id_r;
  logic [QTY_BITS-1:0]      b_qty_r;
  logic [IW-1:0]            b_idx_r;
  logic [IW-1:0]            h_idx_r;
  logic [IW-1:0]            f_idx_r;

  logic sel, elig, better, take, hit, free;

  assign sel  = (cmd_idx == MY_IDX);
  assign elig = valid_r && (side_r != q_buy) &&
                (q_buy ? (price_r <= q_limit) : (price_r >= q_limit));
  assign better = !vld_i.best ||
                  ((price_r != b_price_i) ? (q_buy ? (price_r < b_price_i) : (price_r > b_price_i))
                                          : (id_r < b_id_i));
  assign take = elig && better;
  assign hit  = !vld_i.hit && valid_r && (id_r == q_cid);
  assign free = !vld_i.free && !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      if (sel && cmd_op == lom_pkg::CMD_CLEAR) begin
        valid_r <= 1'b0;
      end else if (sel && cmd_op == lom_pkg::CMD_LOAD) begin
        valid_r <= 1'b1;
      end
      vld_r.best <= vld_i.best || take;
      vld_r.hit  <= vld_i.hit || hit;
      vld_r.free <= vld_i.free || free;
    end
  end

  // slot payload and chain data, no reset needed
  always_ff @(posedge clk) begin
    if (sel && cmd_op == lom_pkg::CMD_LOAD) begin
      id_r    <= cmd_id;
      price_r <= cmd_price;
      qty_r   <= cmd_qty;
      side_r  <= cmd_side;
    end else if (sel && cmd_op == lom_pkg::CMD_DEC) begin
      qty_r <= qty_r - cmd_qty;
    end
    b_price_r <= take ? price_r : b_price_i;
    b_id_r    <= take ? id_r : b_id_i;
    b_qty_r   <= take ? qty_r : b_qty_i;
    b_idx_r   <= take ? MY_IDX : b_idx_i;
    h_idx_r   <= hit ? MY_IDX : h_idx_i;
    f_idx_r   <= free ? MY_IDX : f_idx_i;
  end

  assign vld_o     = vld_r;
  assign b_price_o = b_price_r;
  assign b_id_o    = b_id_r;
  assign b_qty_o   = b_qty_r;
  assign b_idx_o   = b_idx_r;
  assign h_idx_o   = h_idx_r;
  assign f_idx_o   = f_idx_r;

endmodule

### rtl/lom_ctrl.sv
// Request sequencer: holds the query, waits out the chain, emits words, updates slots.
`include "limit_order_matcher_macros.svh"

module lom_ctrl #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24,
  parameter int MAX_ORDERS = 32,
  parameter int IW         = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  lom_in_if.sink                   in_ch,
  lom_out_if.source                out_ch,
  output logic                     q_buy,
  output logic [PRICE_BITS-1:0]    q_limit,
  output logic [lom_pkg::ID_W-1:0] q_cid,
  output lom_pkg::cmd_op_t         cmd_op,
  output logic [IW-1:0]            cmd_idx,
  output logic [lom_pkg::ID_W-1:0] cmd_id,
  output logic [PRICE_BITS-1:0]    cmd_price,
  output logic [QTY_BITS-1:0]      cmd_qty,
  output logic                     cmd_side,
  input  lom_pkg::link_vld_t       end_vld,
  input  logic [PRICE_BITS-1:0]    end_b_price,
  input  logic [lom_pkg::ID_W-1:0] end_b_id,
  input  logic [QTY_BITS-1:0]      end_b_qty,
  input  logic [IW-1:0]            end_b_idx,
  input  logic [IW-1:0]            end_h_idx,
  input  logic [IW-1:0]            end_f_idx
);

  localparam int CW = $clog2(MAX_ORDERS);
  localparam logic [CW-1:0] CNT_LOAD = CW'(MAX_ORDERS - 1);

  lom_pkg::state_t          state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     mode_r, buy_r, rej_r;
  logic [PRICE_BITS-1:0]    limit_r;
  logic [QTY_BITS-1:0]      qty_r, qty_nxt;
  logic [lom_pkg::ID_W-1:0] cid_r, id_r, next_id_r;

  logic                     out_valid_r;
  lom_pkg::kind_t           o_kind_r;
  logic [lom_pkg::ID_W-1:0] o_oid_r, o_maker_r;
  logic [PRICE_BITS-1:0]    o_price_r;
  logic [QTY_BITS-1:0]      o_tq_r, o_left_r;
  logic                     o_last_r;

  logic                     accept, out_free, load;
  lom_pkg::kind_t           res_kind;
  logic [lom_pkg::ID_W-1:0] res_oid, res_maker;
  logic [PRICE_BITS-1:0]    res_price;
  logic [QTY_BITS-1:0]      res_tq, res_left, tq;
  logic                     res_last;

  assign in_ch.ready = (state_r == lom_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign tq          = (qty_r < end_b_qty) ? qty_r : end_b_qty;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    qty_nxt   = qty_r;
    load      = 1'b0;
    res_kind  = lom_pkg::KIND_REJECTED;
    res_oid   = '0;
    res_maker = '0;
    res_price = '0;
    res_tq    = '0;
    res_left  = '0;
    res_last  = 1'b1;
    cmd_op    = lom_pkg::CMD_NONE;
    cmd_idx   = end_b_idx;
    cmd_id    = id_r;
    cmd_price = limit_r;
    cmd_qty   = tq;
    cmd_side  = buy_r;
    case (state_r)
      lom_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = lom_pkg::S_WAIT;
          cnt_nxt   = CNT_LOAD;
        end
      end
      lom_pkg::S_WAIT: begin
        if (cnt_r == '0) begin
          state_nxt = lom_pkg::S_DECIDE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lom_pkg::S_DECIDE: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = lom_pkg::S_IDLE;
          if (mode_r) begin
            res_oid = cid_r;
            if (end_vld.hit) begin
              res_kind = lom_pkg::KIND_CANCELLED;
              cmd_op   = lom_pkg::CMD_CLEAR;
              cmd_idx  = end_h_idx;
            end else begin
              res_kind = lom_pkg::KIND_NOTFOUND;
            end
          end else if (rej_r) begin
            res_kind = lom_pkg::KIND_REJECTED;
          end else if (qty_r != '0 && end_vld.best) begin
            qty_nxt   = qty_r - tq;
            cmd_op    = (end_b_qty == tq) ? lom_pkg::CMD_CLEAR : lom_pkg::CMD_DEC;
            res_kind  = lom_pkg::KIND_TRADE;
            res_oid   = id_r;
            res_maker = end_b_id;
            res_price = end_b_price;
            res_tq    = tq;
            res_left  = qty_r - tq;
            res_last  = 1'b0;
            state_nxt = lom_pkg::S_WAIT;
            cnt_nxt   = CNT_LOAD;
          end else if (qty_r == '0) begin
            res_kind = lom_pkg::KIND_FILLED;
            res_oid  = id_r;
          end else if (end_vld.free) begin
            res_kind = lom_pkg::KIND_RESTED;
            res_oid  = id_r;
            res_left = qty_r;
            cmd_op   = lom_pkg::CMD_LOAD;
            cmd_idx  = end_f_idx;
            cmd_qty  = qty_r;
          end else begin
            res_kind = lom_pkg::KIND_FULL;
            res_oid  = id_r;
          end
        end
      end
      default: begin
        state_nxt = lom_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lom_pkg::S_IDLE;
      cnt_r       <= '0;
      next_id_r   <= lom_pkg::ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept && !in_ch.mode && in_ch.quantity != '0) begin
        next_id_r <= next_id_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_ch.mode;
      buy_r   <= in_ch.is_buy;
      limit_r <= in_ch.limit_price;
      qty_r   <= in_ch.quantity;
      cid_r   <= in_ch.cancel_id;
      rej_r   <= (in_ch.quantity == '0);
      id_r    <= next_id_r;
    end else begin
      qty_r <= qty_nxt;
    end
    if (load) begin
      o_kind_r  <= res_kind;
      o_oid_r   <= res_oid;
      o_maker_r <= res_maker;
      o_price_r <= res_price;
      o_tq_r    <= res_tq;
      o_left_r  <= res_left;
      o_last_r  <= res_last;
    end
  end

  assign q_buy   = buy_r;
  assign q_limit = limit_r;
  assign q_cid   = cid_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = o_kind_r;
  assign out_ch.req_id      = o_oid_r;
  assign out_ch.maker_id    = o_maker_r;
  assign out_ch.trade_price = o_price_r;
  assign out_ch.fill_qty    = o_tq_r;
  assign out_ch.left_qty    = o_left_r;
  assign out_ch.last        = o_last_r;

  `LOM_ASSERT_NEXT(a_accept_waits, accept, state_r == lom_pkg::S_WAIT, "accept did not start wait")
  `LOM_ASSERT_NEXT(a_last_to_idle, load && res_last, state_r == lom_pkg::S_IDLE, "last word not idle")
  `LOM_ASSERT_NOW(a_cmd_on_emit, cmd_op != lom_pkg::CMD_NONE, load, "slot write without word")
  `LOM_ASSERT_NEXT(a_trade_rescans, load && !res_last, cnt_r == CNT_LOAD, "trade without rescan")

endmodule
